>>> sv/shp_pkg.sv
// ----------------------------------------------------------------------------
// shp_pkg
// Shared types and constants for the 3x3 cross sharpen stream.
// ----------------------------------------------------------------------------
`default_nettype none

package shp_pkg;

  localparam int unsigned MAX_LINE_SAMPLES_DEF = 8192;
  localparam int unsigned MAX_ROWS_DEF         = 4096;

  localparam logic [11:0] WIDTH_RST    = 12'd512;
  localparam logic [12:0] HEIGHT_RST   = 13'd512;
  localparam logic [2:0]  CHANNELS_RST = 3'd1;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd2;

  localparam int unsigned OQ_DEPTH = 4;

  // per-word control handed from the position logic to the kernel stage
  typedef struct packed {
    logic [7:0]  sample;
    logic        emit_up;
    logic        emit_low;
    logic        interior;
    logic        role;
    logic [1:0]  tap_sel;
    logic [11:0] row_up;
    logic [11:0] row_low;
    logic [12:0] pos;
  } item_t;

  typedef struct packed {
    logic [7:0]  value;
    logic [11:0] row;
    logic [12:0] pos;
  } res_t;

endpackage

`default_nettype wire

>>> sv/shp_line_store.sv
// ----------------------------------------------------------------------------
// shp_line_store
// One line store: single write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module shp_line_store #(
  parameter int unsigned DEPTH = shp_pkg::MAX_LINE_SAMPLES_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr0,
  input  wire logic [AW-1:0] raddr1,
  output logic      [7:0]    rdata0,
  output logic      [7:0]    rdata1
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-before-write on a shared address
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

`default_nettype wire

>>> sv/shp_pos_ctrl.sv
// ----------------------------------------------------------------------------
// shp_pos_ctrl
// Geometry, raster position counters, line store addressing and the
// clearing sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module shp_pos_ctrl #(
  parameter int unsigned MAX_LINE_SAMPLES = shp_pkg::MAX_LINE_SAMPLES_DEF,
  parameter int unsigned MAX_ROWS         = shp_pkg::MAX_ROWS_DEF,
  localparam int unsigned PW              = $clog2(MAX_LINE_SAMPLES)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [11:0]   width_pixels,
  input  wire logic [12:0]   height_rows,
  input  wire logic [2:0]    channels,
  input  wire logic          accept,
  input  wire logic          frame_start,
  input  wire logic [7:0]    sample,
  output logic               clr_busy,
  output shp_pkg::item_t     item,
  output logic               we_a,
  output logic               we_b,
  output logic [PW-1:0]      waddr,
  output logic [7:0]         wdata,
  output logic [PW-1:0]      raddr_a0,
  output logic [PW-1:0]      raddr_b0,
  output logic [PW-1:0]      raddr_1
);

  import shp_pkg::*;

  localparam int unsigned LW  = PW + 1;
  localparam int unsigned LW1 = LW + 1;
  localparam int unsigned RW  = $clog2(MAX_ROWS);
  localparam int unsigned HW  = RW + 1;
  localparam int unsigned LCW = (LW > 15) ? LW : 15;
  localparam int unsigned HCW = (HW > 13) ? HW : 13;
  localparam logic [LCW-1:0] LINE_MAX = LCW'(MAX_LINE_SAMPLES);
  localparam logic [HCW-1:0] ROWS_MAX = HCW'(MAX_ROWS);
  localparam logic [PW-1:0]  CLR_LAST = PW'(MAX_LINE_SAMPLES - 1);

  logic [RW-1:0] row_r, row_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          role_r, role_nxt;
  logic          clr_busy_r;
  logic [PW-1:0] clr_addr_r;

  logic [2:0]     ch_eff;
  logic [11:0]    w_eff;
  logic [14:0]    prod;
  logic [LCW-1:0] prod_wide;
  logic [LW-1:0]  len;
  logic [12:0]    h_lo;
  logic [HCW-1:0] h_wide;
  logic [HW-1:0]  h_eff;

  logic [HW-1:0]  r0, r1, rn;
  logic [LW-1:0]  p0, p1, pn;
  logic [LW1-1:0] p_plus;
  logic           role1;

  always_comb begin
    if (channels == 3'd0) begin
      ch_eff = 3'd1;
    end else if (channels > 3'd4) begin
      ch_eff = 3'd4;
    end else begin
      ch_eff = channels;
    end
    w_eff     = (width_pixels < 12'd3) ? 12'd3 : width_pixels;
    prod      = 15'(w_eff) * 15'(ch_eff);
    prod_wide = LCW'(prod);
    len       = (prod_wide > LINE_MAX) ? LW'(LINE_MAX) : LW'(prod_wide);
    h_lo      = (height_rows < 13'd3) ? 13'd3 : height_rows;
    h_wide    = HCW'(h_lo);
    h_eff     = (h_wide > ROWS_MAX) ? HW'(ROWS_MAX) : HW'(h_wide);
  end

  // position of the incoming word, then the counters after it
  always_comb begin
    r0    = frame_start ? '0 : {1'b0, row_r};
    p0    = frame_start ? '0 : {1'b0, pos_r};
    r1    = r0;
    p1    = p0;
    role1 = role_r;
    if (p0 >= len) begin
      p1    = '0;
      r1    = r0 + HW'(1);
      role1 = ~role_r;
    end
    if (r1 >= h_eff) begin
      r1 = '0;
    end
    pn       = p1 + LW'(1);
    rn       = r1 + HW'(1);
    p_plus   = {1'b0, p1} + LW1'(ch_eff);
    row_nxt  = row_r;
    pos_nxt  = pos_r;
    role_nxt = role_r;
    if (accept) begin
      if (pn >= len) begin
        pos_nxt  = '0;
        row_nxt  = (rn >= h_eff) ? '0 : RW'(rn);
        role_nxt = ~role1;
      end else begin
        pos_nxt  = PW'(pn);
        row_nxt  = RW'(r1);
        role_nxt = role1;
      end
    end
  end

  always_comb begin
    item.sample   = sample;
    item.emit_up  = (r1 != '0);
    item.emit_low = (r1 == h_eff - HW'(1));
    item.interior = (r1 >= HW'(2)) && (p1 >= LW'(ch_eff)) && (p_plus < LW1'(len));
    item.role     = role1;
    item.tap_sel  = 2'(ch_eff - 3'd1);
    item.row_up   = 12'(r1 - HW'(1));
    item.row_low  = 12'(r1);
    item.pos      = 13'(p1);
  end

  // role 0: store a holds the older row, store b the previous row
  always_comb begin
    we_a     = clr_busy_r | (accept & ~role1);
    we_b     = clr_busy_r | (accept & role1);
    waddr    = clr_busy_r ? clr_addr_r : PW'(p1);
    wdata    = clr_busy_r ? 8'd0 : sample;
    raddr_a0 = role1 ? PW'(p_plus) : PW'(p1);
    raddr_b0 = role1 ? PW'(p1) : PW'(p_plus);
    raddr_1  = PW'(p1 - LW'(ch_eff));
  end

  assign clr_busy = clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      pos_r      <= '0;
      role_r     <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      row_r  <= row_nxt;
      pos_r  <= pos_nxt;
      role_r <= role_nxt;
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + PW'(1);
        if (clr_addr_r == CLR_LAST) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/shp_kernel.sv
// ----------------------------------------------------------------------------
// shp_kernel
// Read-data stage: centre tap line, cross kernel and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module shp_kernel (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire shp_pkg::item_t item_in,
  input  wire logic           room,
  input  wire logic [7:0]     a_rd0,
  input  wire logic [7:0]     a_rd1,
  input  wire logic [7:0]     b_rd0,
  input  wire logic [7:0]     b_rd1,
  output logic                busy,
  output logic [1:0]          push_n,
  output shp_pkg::res_t       res0,
  output shp_pkg::res_t       res1
);

  import shp_pkg::*;

  item_t      s1_r;
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] taps_r [4];

  logic        adv;
  logic [7:0]  up, right, left, mid;
  logic [11:0] five, acc;
  logic [7:0]  sat;

  assign adv  = s1_valid_r & room;
  assign busy = s1_valid_r;

  always_comb begin
    if (s1_r.role) begin
      up    = b_rd0;
      right = a_rd0;
      left  = a_rd1;
    end else begin
      up    = a_rd0;
      right = b_rd0;
      left  = b_rd1;
    end
    mid  = taps_r[s1_r.tap_sel];
    five = {2'b00, mid, 2'b00} + {4'h0, mid};
    acc  = five - {4'h0, left} - {4'h0, right} - {4'h0, up} - {4'h0, s1_r.sample};
    if (acc[11]) begin
      sat = 8'd0;
    end else if (acc > 12'd255) begin
      sat = 8'd255;
    end else begin
      sat = acc[7:0];
    end
    res0.value = s1_r.interior ? sat : 8'd0;
    res0.row   = s1_r.row_up;
    res0.pos   = s1_r.pos;
    res1.value = 8'd0;
    res1.row   = s1_r.row_low;
    res1.pos   = s1_r.pos;
    push_n     = adv ? ({1'b0, s1_r.emit_up} + {1'b0, s1_r.emit_low & s1_r.emit_up}) : 2'd0;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= item_in;
    end
    if (adv) begin
      taps_r[0] <= right;
      taps_r[1] <= taps_r[0];
      taps_r[2] <= taps_r[1];
      taps_r[3] <= taps_r[2];
    end
  end

endmodule

`default_nettype wire

>>> sv/shp_out_queue.sv
// ----------------------------------------------------------------------------
// shp_out_queue
// Small result queue, up to two words pushed per cycle, one popped when the output does not stall.
// ----------------------------------------------------------------------------
`default_nettype none

module shp_out_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [1:0]    push_n,
  input  wire shp_pkg::res_t res0,
  input  wire shp_pkg::res_t res1,
  input  wire logic          out_stall,
  output logic               out_valid,
  output logic [7:0]         out_value,
  output logic [11:0]        out_row,
  output logic [12:0]        out_pos,
  output logic               room
);

  import shp_pkg::*;

  localparam int unsigned QPW = $clog2(OQ_DEPTH);
  localparam int unsigned CW  = QPW + 1;

  res_t           q_r [OQ_DEPTH];
  logic [QPW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid & ~out_stall;
  assign room      = (count_r <= CW'(OQ_DEPTH - 2));
  assign out_value = q_r[rd_ptr_r].value;
  assign out_row   = q_r[rd_ptr_r].row;
  assign out_pos   = q_r[rd_ptr_r].pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPW'(push_n);
      rd_ptr_r <= rd_ptr_r + QPW'(pop);
      count_r  <= count_r + CW'(push_n) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      q_r[QPW'(wr_ptr_r + QPW'(1))] <= res1;
    end
  end

endmodule

`default_nettype wire

>>> sv/sharpen_3x3_stream.sv
// ----------------------------------------------------------------------------
// sharpen_3x3_stream
// Streaming 3x3 cross sharpen over an interleaved 8-bit image.
// ----------------------------------------------------------------------------
// Takes one sample word per clock while in_stall is low and returns each
// sharpened word, one row behind the input, via the kernel stage register
// and the result queue. On every row but the last one word goes in per cycle
// while the output does not stall; on the last row each input word yields two
// result words (the row above and the zero bottom border), so the single
// result channel sets the pace there. Two line stores, each one write and two
// registered reads per cycle, hold the two previous rows; the left neighbour
// comes from the second read port and the centre from a short tap line on the
// first. After reset the line stores are swept to zero, all MAX_LINE_SAMPLES
// addresses (8192 by default), with in_stall high. Configuration writes are
// taken in any cycle and must only be made while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sharpen_3x3_stream #(
  parameter int unsigned MAX_LINE_SAMPLES = shp_pkg::MAX_LINE_SAMPLES_DEF,
  parameter int unsigned MAX_ROWS         = shp_pkg::MAX_ROWS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_sample,
  input  wire logic                           in_frame_start,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [7:0]                          out_value,
  output logic [11:0]                         out_row,
  output logic [12:0]                         out_pos,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [shp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [12:0]                    cfg_data
);

  import shp_pkg::*;

  localparam int unsigned PW = $clog2(MAX_LINE_SAMPLES);

  logic [11:0] width_r;
  logic [12:0] height_r;
  logic [2:0]  channels_r;

  logic          accept, clr_busy, k_busy, room;
  item_t         item;
  logic          we_a, we_b;
  logic [PW-1:0] waddr, raddr_a0, raddr_b0, raddr_1;
  logic [7:0]    wdata, a_rd0, a_rd1, b_rd0, b_rd1;
  logic [1:0]    push_n;
  res_t          res0, res1;

  assign cfg_ready = 1'b1;
  assign in_stall  = clr_busy | (k_busy & ~room);
  assign accept    = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WIDTH_RST;
      height_r   <= HEIGHT_RST;
      channels_r <= CHANNELS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WIDTH:    width_r    <= cfg_data[11:0];
        CFG_HEIGHT:   height_r   <= cfg_data;
        CFG_CHANNELS: channels_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  shp_pos_ctrl #(
    .MAX_LINE_SAMPLES(MAX_LINE_SAMPLES),
    .MAX_ROWS(MAX_ROWS)
  ) u_pos (
    .clk(clk),
    .rst_n(rst_n),
    .width_pixels(width_r),
    .height_rows(height_r),
    .channels(channels_r),
    .accept(accept),
    .frame_start(in_frame_start),
    .sample(in_sample),
    .clr_busy(clr_busy),
    .item(item),
    .we_a(we_a),
    .we_b(we_b),
    .waddr(waddr),
    .wdata(wdata),
    .raddr_a0(raddr_a0),
    .raddr_b0(raddr_b0),
    .raddr_1(raddr_1)
  );

  shp_line_store #(.DEPTH(MAX_LINE_SAMPLES)) u_store_a (
    .clk(clk),
    .we(we_a),
    .waddr(waddr),
    .wdata(wdata),
    .re(accept),
    .raddr0(raddr_a0),
    .raddr1(raddr_1),
    .rdata0(a_rd0),
    .rdata1(a_rd1)
  );

  shp_line_store #(.DEPTH(MAX_LINE_SAMPLES)) u_store_b (
    .clk(clk),
    .we(we_b),
    .waddr(waddr),
    .wdata(wdata),
    .re(accept),
    .raddr0(raddr_b0),
    .raddr1(raddr_1),
    .rdata0(b_rd0),
    .rdata1(b_rd1)
  );

  shp_kernel u_kernel (
    .clk(clk),
    .rst_n(rst_n),
    .accept(accept),
    .item_in(item),
    .room(room),
    .a_rd0(a_rd0),
    .a_rd1(a_rd1),
    .b_rd0(b_rd0),
    .b_rd1(b_rd1),
    .busy(k_busy),
    .push_n(push_n),
    .res0(res0),
    .res1(res1)
  );

  shp_out_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push_n(push_n),
    .res0(res0),
    .res1(res1),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_value(out_value),
    .out_row(out_row),
    .out_pos(out_pos),
    .room(room)
  );

endmodule

`default_nettype wire

>>> sv/shp_checker.sv
// ----------------------------------------------------------------------------
// shp_checker
// Port-level checks on the sharpen stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module shp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  out_value,
  input wire logic [11:0] out_row,
  input wire logic [12:0] out_pos
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_row)
      && $stable(out_pos))
    else $error("stalled result word changed");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("reset left input open or result pending");

  a_clear_sweep: assert property (@(posedge clk)
    !rst_n ##1 rst_n |=> in_stall)
    else $error("input taken during line store clear");

  a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_value != 8'd0 |-> out_row != 12'd0 && out_pos != 13'd0)
    else $error("nonzero word on top row or first column");

endmodule

bind sharpen_3x3_stream shp_checker u_chk (.*);

`default_nettype wire
